// ----- hw/rtl/plbl_pkg.sv -----
// Shared types, constants and the sRGB linearization table for the lightness block.
`default_nettype none

package plbl_pkg;

   // Field and register widths.
   localparam int PIXEL_W  = 32;
   localparam int L_W      = 15;
   localparam int WEIGHT_W = 17;
   localparam int LIN_W    = 17;
   localparam int Y_W      = 33;
   localparam int ROOT_W   = 17;
   localparam int CSR_IDX_W = 2;

   // Cube root pipeline: one root bit per stage, three radicand bits per stage.
   localparam int CBRT_STAGES = 17;
   localparam int RAD_W       = 3 * CBRT_STAGES;
   localparam int REM_W       = 52;
   localparam int YSQ_W       = 2 * ROOT_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_BLUE  = 2'd2;

   // Reset weights, Q0.16.
   localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 17'd13933;
   localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 17'd46871;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 17'd4732;

   // Luminance limits and the L* scaling constants.
   localparam logic [Y_W-1:0] Y_FULL = 33'h1_0000_0000;
   localparam logic [Y_W-1:0] Y_KNEE = Y_W'((64'd216 << 32) / 64'd24389);
   localparam int KNEE_W = 26;
   localparam logic [17:0] LIN_SLOPE = 18'd231244;
   localparam logic [L_W-1:0] L_MAX = 15'd25600;
   localparam logic [L_W-1:0] L_OFFSET = 15'd4096;

   // Data that rides along the cube root pipeline.
   typedef struct packed {
      logic           lin_sel;
      logic [L_W-1:0] lin_l;
   } side_type;

   typedef logic [LIN_W-1:0] lin_rom_type [256];

   // (a * b) >> 62 kept at 64 bits.
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // One entry of the sRGB to linear light curve, Q0.16, rounded half up.
   // The power 2.4 is evaluated as the fifth root of the twelfth power, so the
   // largest r with ((2r-1)/2^17)^5 <= v^12 is the rounded value.
   function automatic logic [LIN_W-1:0] lin_entry(input int c);
      logic [63:0] num;
      logic [63:0] q1;
      logic [63:0] rem;
      logic [63:0] v;
      logic [63:0] v2;
      logic [63:0] v4;
      logic [63:0] v8;
      logic [63:0] v12;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] t5;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      if (c <= 10) begin
         return LIN_W'((64'd1310720 * 64'(c) + 64'd32946) / 64'd65892);
      end
      num = 64'd1000 * 64'(c) + 64'd14025;
      q1  = (num << 44) / 64'd269025;
      rem = (num << 44) % 64'd269025;
      v   = (q1 << 18) + (rem << 18) / 64'd269025;
      if (v > (64'd1 << 62)) begin
         v = 64'd1 << 62;
      end
      v2  = q62_mul(v, v);
      v4  = q62_mul(v2, v2);
      v8  = q62_mul(v4, v4);
      v12 = q62_mul(v8, v4);
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t   = (64'(2 * mid) - 64'd1) << 45;
         t2  = q62_mul(t, t);
         t5  = q62_mul(q62_mul(t2, t2), t);
         if (t5 <= v12) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return LIN_W'(lo);
   endfunction

   function automatic lin_rom_type build_lin_rom();
      lin_rom_type t;
      for (int c = 0; c < 256; c++) begin
         t[c] = lin_entry(c);
      end
      return t;
   endfunction

   localparam lin_rom_type LIN_ROM = build_lin_rom();

endpackage

`default_nettype wire

// ----- hw/rtl/plbl_req_if.sv -----
// Input channel: one packed pixel per transfer.
`default_nettype none

interface plbl_req_if;
   logic                         valid;
   logic                         ready;
   logic [plbl_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/plbl_rsp_if.sv -----
// Result channel: one lightness value per transfer.
`default_nettype none

interface plbl_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [plbl_pkg::L_W-1:0] lightness;

   modport source (output valid, output lightness, input ready);
   modport sink   (input valid, input lightness, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/plbl_cbrt.sv -----
// Pipelined bitwise integer cube root, one root bit per stage, with sideband data.
`default_nettype none

module plbl_cbrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire logic [plbl_pkg::RAD_W-1:0]    in_x,
   input  wire plbl_pkg::side_type            in_side,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      logic [plbl_pkg::ROOT_W-1:0]   out_root,
   output      plbl_pkg::side_type            out_side
);

   localparam int NST = plbl_pkg::CBRT_STAGES;

   logic [NST-1:0]                 v_ff;
   logic [NST:0]                   en;
   logic [plbl_pkg::REM_W-1:0]     rem_ff  [NST];
   logic [plbl_pkg::ROOT_W-1:0]    y_ff    [NST];
   logic [plbl_pkg::YSQ_W-1:0]     ysq_ff  [NST];
   logic [plbl_pkg::RAD_W-1:0]     x_ff    [NST];
   plbl_pkg::side_type             side_ff [NST];

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NST-1];
   assign out_root  = y_ff[NST-1];
   assign out_side  = side_ff[NST-1];

   genvar k;
   for (k = 0; k < NST; k++) begin : g_stage
      logic [plbl_pkg::REM_W-1:0]  rem_i;
      logic [plbl_pkg::ROOT_W-1:0] y_i;
      logic [plbl_pkg::YSQ_W-1:0]  ysq_i;
      logic [plbl_pkg::RAD_W-1:0]  x_i;
      plbl_pkg::side_type          side_i;
      logic                        v_i;
      logic [plbl_pkg::REM_W-1:0]  r_w;
      logic [plbl_pkg::REM_W-1:0]  b_w;
      logic [plbl_pkg::REM_W-1:0]  rem_in;
      logic [plbl_pkg::ROOT_W-1:0] y_in;
      logic [plbl_pkg::YSQ_W-1:0]  ysq_in;

      // Stage inputs come from the port or the previous stage.
      if (k == 0) begin : g_first
         assign rem_i  = '0;
         assign y_i    = '0;
         assign ysq_i  = '0;
         assign x_i    = in_x;
         assign side_i = in_side;
         assign v_i    = in_valid;
      end else begin : g_next
         assign rem_i  = rem_ff[k-1];
         assign y_i    = y_ff[k-1];
         assign ysq_i  = ysq_ff[k-1];
         assign x_i    = x_ff[k-1];
         assign side_i = side_ff[k-1];
         assign v_i    = v_ff[k-1];
      end

      // Bring down three radicand bits and try the next root bit as one.
      // Subtrahend is 3*(2y)*(2y+1)+1 = 12*y^2 + 6*y + 1.
      always_comb begin
         r_w = {rem_i[plbl_pkg::REM_W-4:0], x_i[plbl_pkg::RAD_W-1 -: 3]};
         b_w = (plbl_pkg::REM_W'(ysq_i) << 3) + (plbl_pkg::REM_W'(ysq_i) << 2)
             + (plbl_pkg::REM_W'(y_i) << 2) + (plbl_pkg::REM_W'(y_i) << 1)
             + plbl_pkg::REM_W'(1);
         if (r_w >= b_w) begin
            rem_in = r_w - b_w;
            y_in   = {y_i[plbl_pkg::ROOT_W-2:0], 1'b1};
            ysq_in = (ysq_i << 2) + (plbl_pkg::YSQ_W'(y_i) << 2) + plbl_pkg::YSQ_W'(1);
         end else begin
            rem_in = r_w;
            y_in   = {y_i[plbl_pkg::ROOT_W-2:0], 1'b0};
            ysq_in = ysq_i << 2;
         end
      end

      // Stage registers.
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_i;
         end
         if (en[k]) begin
            rem_ff[k]  <= rem_in;
            y_ff[k]    <= y_in;
            ysq_ff[k]  <= ysq_in;
            x_ff[k]    <= x_i << 3;
            side_ff[k] <= side_i;
         end
      end
   end

   // An accepted radicand enters the first stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> v_ff[0])
      else $error("cube root input transfer did not reach the first stage");

   // A stalled result holds its root and sideband.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_root) && $stable(out_side))
      else $error("stalled cube root result changed");

   // The root of a radicand up to 2^48 never exceeds 2^16.
   a_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_root <= plbl_pkg::ROOT_W'(65536))
      else $error("cube root out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/pixel_perceptual_lightness.sv -----
// Top level: CIE L* lightness of a packed ARGB pixel stream.
//
// Usage: pixels arrive on the req channel (valid/ready, field pixel, alpha in
// bits 31:24 ignored) and one L* value per pixel leaves on the rsp channel in
// unsigned Q7.8 (0 to 25600). Three luminance weights in Q0.16 are written on
// the csr port (index 0 red, 1 green, 2 blue) while the block is idle.
// The pipeline holds 22 register stages: table lookup, weight multiply,
// luminance sum, linear segment multiply, 17 cube root stages that resolve
// one root bit each, and the output register. Throughput is one pixel per
// cycle while the receiver keeps taking results; every stage is a register
// with its own valid bit and a stage loads whenever it is empty or its item
// moves on. When the receiver stalls, the result is held and items behind it
// close up into empty stages, so the input keeps taking pixels until the
// pipe is full.
// Synchronous reset empties the pipeline and restores the default weights
// (0.2126, 0.7152, 0.0722).
`default_nettype none

module pixel_perceptual_lightness (
   input  wire logic                             clock,
   input  wire logic                             reset,
   plbl_req_if.sink                              req,
   plbl_rsp_if.source                            rsp,
   input  wire logic                             csr_we,
   input  wire logic [plbl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [plbl_pkg::WEIGHT_W-1:0]    csr_wdata
);

   logic [plbl_pkg::WEIGHT_W-1:0] wr_ff, wg_ff, wb_ff;

   logic                         v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   logic                         en1, en2, en3, en4, eno;
   logic [plbl_pkg::LIN_W-1:0]   lr_ff, lg_ff, lb_ff;
   logic [33:0]                  pr_ff, pg_ff, pb_ff;
   logic [plbl_pkg::Y_W-1:0]     y3_ff;
   logic [35:0]                  ysum;
   logic [plbl_pkg::Y_W-1:0]     y3_in;
   logic [43:0]                  lin_prod;
   logic [plbl_pkg::L_W-1:0]     lin_l;
   logic [plbl_pkg::RAD_W-1:0]   x4_ff;
   plbl_pkg::side_type           side4_ff;
   logic [plbl_pkg::L_W-1:0]     l_ff;
   logic [plbl_pkg::L_W-1:0]     l_in;

   logic                         cb_ready;
   logic                         cb_valid;
   logic [plbl_pkg::ROOT_W-1:0]  cb_root;
   plbl_pkg::side_type           cb_side;
   logic [24:0]                  s_wide;
   logic [16:0]                  s_val;

   // Weight registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= plbl_pkg::WEIGHT_RED_RST;
         wg_ff <= plbl_pkg::WEIGHT_GREEN_RST;
         wb_ff <= plbl_pkg::WEIGHT_BLUE_RST;
      end else if (csr_we) begin
         case (csr_index)
            plbl_pkg::CSR_WEIGHT_RED:   wr_ff <= csr_wdata;
            plbl_pkg::CSR_WEIGHT_GREEN: wg_ff <= csr_wdata;
            plbl_pkg::CSR_WEIGHT_BLUE:  wb_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when empty or when its item moves on.
   assign eno = !vo_ff || rsp.ready;
   assign en4 = !v4_ff || cb_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req.ready = en1;

   // Stage 1: linearize each channel through the curve table.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req.valid;
      end
      if (en1) begin
         lr_ff <= plbl_pkg::LIN_ROM[req.pixel[23:16]];
         lg_ff <= plbl_pkg::LIN_ROM[req.pixel[15:8]];
         lb_ff <= plbl_pkg::LIN_ROM[req.pixel[7:0]];
      end
   end

   // Stage 2: weight each linear channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         pr_ff <= wr_ff * lr_ff;
         pg_ff <= wg_ff * lg_ff;
         pb_ff <= wb_ff * lb_ff;
      end
   end

   // Stage 3: luminance sum, saturated at full scale.
   always_comb begin
      ysum = 36'(pr_ff) + 36'(pg_ff) + 36'(pb_ff);
      if (ysum > 36'(plbl_pkg::Y_FULL)) begin
         y3_in = plbl_pkg::Y_FULL;
      end else begin
         y3_in = ysum[plbl_pkg::Y_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         y3_ff <= y3_in;
      end
   end

   // Stage 4: linear segment for dark values; the knee fits in 26 bits.
   assign lin_prod = y3_ff[plbl_pkg::KNEE_W-1:0] * plbl_pkg::LIN_SLOPE
                   + 44'h0_8000_0000;
   assign lin_l    = plbl_pkg::L_W'(lin_prod[43:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
      if (en4) begin
         x4_ff            <= plbl_pkg::RAD_W'({y3_ff, 16'h0000});
         side4_ff.lin_sel <= (y3_ff <= plbl_pkg::Y_KNEE);
         side4_ff.lin_l   <= lin_l;
      end
   end

   plbl_cbrt u_cbrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_ready  (cb_ready),
      .in_x      (x4_ff),
      .in_side   (side4_ff),
      .out_valid (cb_valid),
      .out_ready (eno),
      .out_root  (cb_root),
      .out_side  (cb_side)
   );

   // Output stage: linear L if dark, else root*116/256 less offset, clamped.
   always_comb begin
      s_wide = 25'(cb_root) * 25'd116 + 25'd128;
      s_val  = s_wide[24:8];
      if (cb_side.lin_sel) begin
         l_in = cb_side.lin_l;
      end else if (s_val <= 17'(plbl_pkg::L_OFFSET)) begin
         l_in = '0;
      end else if (s_val - 17'(plbl_pkg::L_OFFSET) > 17'(plbl_pkg::L_MAX)) begin
         l_in = plbl_pkg::L_MAX;
      end else begin
         l_in = plbl_pkg::L_W'(s_val - 17'(plbl_pkg::L_OFFSET));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (eno) begin
         vo_ff <= cb_valid;
      end
      if (eno) begin
         l_ff <= l_in;
      end
   end

   assign rsp.valid     = vo_ff;
   assign rsp.lightness = l_ff;

   // Results never leave the Q7.8 range 0 to 100.
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.lightness <= plbl_pkg::L_MAX)
      else $error("lightness out of range");

   // A stalled result is held for the receiver.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.lightness))
      else $error("stalled result changed");

   // Input is always taken while the first stage is empty.
   a_in_ready: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req.ready)
      else $error("input refused with an empty first stage");

endmodule

`default_nettype wire

// ----- bench/pixel_perceptual_lightness_tb.sv -----
// Self-checking testbench for the pixel lightness block against an integer predictor.
`default_nettype none

module pixel_perceptual_lightness_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_LIMIT    = 3000;
   localparam int LONG_HOLD     = 300;
   localparam logic [plbl_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [plbl_pkg::CSR_IDX_W-1:0] csr_index;
   logic [plbl_pkg::WEIGHT_W-1:0]  csr_wdata;

   plbl_req_if req_ch ();
   plbl_rsp_if rsp_ch ();

   pixel_perceptual_lightness uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Bench copy of the weights and the linear light table.
   logic [plbl_pkg::WEIGHT_W-1:0] wt_red, wt_green, wt_blue;
   logic [plbl_pkg::LIN_W-1:0]    linear_table [256];

   logic [plbl_pkg::PIXEL_W-1:0] pixel_queue [$];
   logic [plbl_pkg::L_W-1:0]     lightness_due [$];
   int  errors = 0;
   int  results_seen = 0;
   bit  calm = 1'b0;
   bit  req_taken = 1'b0;
   int  send_gap = 0;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;
   int  idle_cycles = 0;

   // (a * b) >> 62 at 64 bits.
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // sRGB curve entry in Q0.16, exact integer form.
   function automatic logic [plbl_pkg::LIN_W-1:0] srgb_to_linear(input int unsigned c);
      logic [63:0] num, q1, rem, v, v2, v4, v8, v12, t, t2, t5;
      int unsigned lo, hi, mid;
      if (c <= 10) begin
         return plbl_pkg::LIN_W'((64'd1310720 * c + 64'd32946) / 64'd65892);
      end
      num = 64'd1000 * c + 64'd14025;
      q1  = (num << 44) / 64'd269025;
      rem = (num << 44) % 64'd269025;
      v   = (q1 << 18) + (rem << 18) / 64'd269025;
      if (v > (64'd1 << 62)) begin
         v = 64'd1 << 62;
      end
      v2  = q62_mul(v, v);
      v4  = q62_mul(v2, v2);
      v8  = q62_mul(v4, v4);
      v12 = q62_mul(v8, v4);
      // Largest r with ((2r-1)/2^17)^5 <= v^12.
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t   = (64'(2 * mid) - 64'd1) << 45;
         t2  = q62_mul(t, t);
         t5  = q62_mul(q62_mul(t2, t2), t);
         if (t5 <= v12) lo = mid;
         else hi = mid - 1;
      end
      return plbl_pkg::LIN_W'(lo);
   endfunction

   // Expected L* in Q7.8 for one pixel under the current weights.
   function automatic logic [plbl_pkg::L_W-1:0] predict_lightness(
         input logic [plbl_pkg::PIXEL_W-1:0] px);
      logic [63:0] y, l, x, root, s, lo, hi, mid;
      y = 64'(wt_red) * linear_table[px[23:16]]
        + 64'(wt_green) * linear_table[px[15:8]]
        + 64'(wt_blue) * linear_table[px[7:0]];
      if (y > 64'(plbl_pkg::Y_FULL)) y = 64'(plbl_pkg::Y_FULL);
      if (y <= (64'd216 << 32) / 64'd24389) begin
         l = (y * 64'd231244 + (64'd1 << 31)) >> 32;
      end else begin
         x  = y << 16;
         lo = 0;
         hi = 65536;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * mid <= x) lo = mid;
            else hi = mid - 1;
         end
         root = lo;
         s = (64'd116 * root + 64'd128) >> 8;
         l = (s > 64'd4096) ? s - 64'd4096 : 64'd0;
      end
      if (l > 64'd25600) l = 64'd25600;
      return plbl_pkg::L_W'(l);
   endfunction

   // Register write on the csr port, mirrored into the bench weights.
   task automatic write_weight(input logic [plbl_pkg::CSR_IDX_W-1:0] idx,
                               input logic [plbl_pkg::WEIGHT_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         plbl_pkg::CSR_WEIGHT_RED:   wt_red = val;
         plbl_pkg::CSR_WEIGHT_GREEN: wt_green = val;
         plbl_pkg::CSR_WEIGHT_BLUE:  wt_blue = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_weights(input logic [plbl_pkg::WEIGHT_W-1:0] r,
                              input logic [plbl_pkg::WEIGHT_W-1:0] g,
                              input logic [plbl_pkg::WEIGHT_W-1:0] b);
      write_weight(plbl_pkg::CSR_WEIGHT_RED, r);
      write_weight(plbl_pkg::CSR_WEIGHT_GREEN, g);
      write_weight(plbl_pkg::CSR_WEIGHT_BLUE, b);
   endtask

   // Wait until every queued pixel has gone in and every result has come back.
   task automatic drain();
      wait (pixel_queue.size() == 0 && !req_ch.valid && lightness_due.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random pixels, biased toward greys, dark values, the curve's corners and blue-only pixels.
   task automatic queue_random(input int count);
      logic [7:0] corner [4];
      logic [plbl_pkg::PIXEL_W-1:0] px;
      int mode;
      corner = '{8'd0, 8'd10, 8'd11, 8'd255};
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         px = $urandom;
         case (mode)
            6: px[15:0] = {px[23:16], px[23:16]};
            7: begin
               px[23:16] = 8'($urandom_range(0, 15));
               px[15:8]  = 8'($urandom_range(0, 15));
               px[7:0]   = 8'($urandom_range(0, 15));
            end
            8: begin
               px[23:16] = corner[$urandom_range(0, 3)];
               px[15:8]  = corner[$urandom_range(0, 3)];
               px[7:0]   = corner[$urandom_range(0, 3)];
            end
            9: px[23:8] = 16'd0;
            default: ;
         endcase
         pixel_queue.push_back(px);
      end
   endtask

   // Input side: note each transfer and predict its result.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_ch.valid && req_ch.ready) begin
         req_taken = 1'b1;
         lightness_due.push_back(predict_lightness(req_ch.pixel));
      end
   end

   // Driver: offers the next pixel after a transfer, with random gaps.
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (send_gap == 0 && !calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 14);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            req_ch.pixel <= pixel_queue.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts, and one long hold so the pipeline backs up.
   always @(negedge clock) begin
      if (!long_hold_done && results_seen >= 500) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD;
      end else if (hold_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(1, 14);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      logic [plbl_pkg::L_W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (lightness_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected lightness %0d", $realtime, rsp_ch.lightness);
         end else begin
            want = lightness_due.pop_front();
            if (rsp_ch.lightness !== want) begin
               errors++;
               $display("%0t: lightness expected %0d, actual %0d",
                        $realtime, want, rsp_ch.lightness);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Stimulus: directed corners, then random phases over several weight settings.
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = plbl_pkg::CSR_WEIGHT_RED;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      rsp_ch.ready = 1'b0;
      wt_red = plbl_pkg::WEIGHT_RED_RST;
      wt_green = plbl_pkg::WEIGHT_GREEN_RST;
      wt_blue = plbl_pkg::WEIGHT_BLUE_RST;
      for (int c = 0; c < 256; c++) begin
         linear_table[c] = srgb_to_linear(c);
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: black, white, primaries, alpha extremes, dark segment and the knee.
      pixel_queue = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000,
                      32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hAA01_0101,
                      32'h000A_0A0A, 32'h550B_0B0B, 32'h0014_1414, 32'h001C_1C1C,
                      32'h001D_1D1D, 32'h001E_1E1E, 32'h0080_8080, 32'h00AA_AAAA,
                      32'h000A_0000, 32'h0000_0B00, 32'h00FE_FEFE, 32'h8001_0000};
      queue_random(300);
      drain();

      // Zero weights, then full scale, then 17-bit maximum with saturation.
      set_weights(17'd0, 17'd0, 17'd0);
      pixel_queue = '{32'hFFFF_FFFF, 32'h0080_8080};
      queue_random(60);
      drain();
      set_weights(17'd65536, 17'd65536, 17'd65536);
      pixel_queue = '{32'h00FF_FFFF, 32'h0000_0001, 32'h000A_0A0A};
      queue_random(250);
      drain();
      set_weights(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      write_weight(CSR_UNUSED, 17'h0_5555);
      pixel_queue = '{32'h00FF_FFFF, 32'h0000_0000, 32'h0001_0000};
      queue_random(250);
      drain();

      // Red at its largest weight, green at zero, blue at its least nonzero weight, and the unused index.
      set_weights(17'h1FFFF, 17'd0, 17'd1);
      write_weight(CSR_UNUSED, 17'h1FFFF);
      queue_random(250);
      drain();

      // Random weights.
      for (int k = 0; k < 3; k++) begin
         set_weights(plbl_pkg::WEIGHT_W'($urandom_range(0, 65536)),
                     plbl_pkg::WEIGHT_W'($urandom_range(0, 65536)),
                     plbl_pkg::WEIGHT_W'($urandom_range(0, 131071)));
         queue_random(200);
         drain();
      end

      // Back to the default weights, no idling on either side.
      set_weights(plbl_pkg::WEIGHT_RED_RST, plbl_pkg::WEIGHT_GREEN_RST,
                  plbl_pkg::WEIGHT_BLUE_RST);
      calm = 1'b1;
      queue_random(200);
      drain();

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
